@@ hdl/est_pkg.sv @@
package est_pkg;

  // Counter and result field widths
  localparam int CNT_W    = 16;
  localparam int DELTA_W  = 16;
  localparam int ACC_W    = 18;
  localparam int TRV_W    = 17;
  localparam int SUM_W    = ACC_W + 1;
  localparam int Q_W      = 32;
  localparam int FRAC_W   = 16;

  // Configuration register widths
  localparam int CPR_W    = 16;
  localparam int WC_W     = 32;
  localparam int PER_W    = 24;
  localparam int NLR_W    = 15;

  // Arithmetic unit widths
  localparam int DEN_W    = CPR_W + PER_W;
  localparam int PROD_W   = 2 * Q_W;
  localparam int STEPS    = Q_W / 2;
  localparam int STEP_W   = $clog2(STEPS);

  // Configuration port
  localparam int IDX_W    = 2;
  localparam int ADDR_W   = IDX_W + 2;
  localparam int DATA_W   = 32;

  localparam logic [CPR_W-1:0] CPR_RST = CPR_W'(4096);
  localparam logic [WC_W-1:0]  WC_RST  = WC_W'(65536);
  localparam logic [PER_W-1:0] PER_RST = PER_W'(1000);
  localparam logic [NLR_W-1:0] NLR_RST = NLR_W'(32767);

  localparam int USEC_PER_SEC = 1000000;
  localparam int USEC_PER_MIN = 60000000;
  localparam int QUAD_EDGES   = 4;

  localparam logic [Q_W-1:0] VEL_K = Q_W'(USEC_PER_SEC);
  localparam logic [Q_W-1:0] RPM_K = Q_W'(USEC_PER_MIN / QUAD_EDGES);

  localparam logic [Q_W-1:0] POS_LIM = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic [Q_W-1:0] NEG_LIM = {1'b1, {(Q_W-1){1'b0}}};

  typedef enum logic [IDX_W-1:0] {
    REG_CPR = 2'd0,
    REG_WC  = 2'd1,
    REG_PER = 2'd2,
    REG_NLR = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_DIST = 2'd0,
    OP_VEL  = 2'd1,
    OP_RPM  = 2'd2
  } op_t;

  typedef struct packed {
    logic [CPR_W-1:0] cpr;
    logic [WC_W-1:0]  wc;
    logic [PER_W-1:0] per;
    logic [NLR_W-1:0] nlr;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic div_init;
    logic div_step;
    logic fin;
    logic out_load;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic step_last;
  } status_t;

endpackage

@@ hdl/est_if.sv @@
interface est_sample_if;
  import est_pkg::*;

  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] counter_value;

  modport source (output valid, output counter_value, input ready);
  modport sink (input valid, input counter_value, output ready);
endinterface

interface est_result_if;
  import est_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [DELTA_W-1:0] delta_counts;
  logic signed [TRV_W-1:0]   travel_counts;
  logic signed [Q_W-1:0]     travel_revolutions;
  logic signed [Q_W-1:0]     distance_delta;
  logic signed [Q_W-1:0]     velocity;
  logic signed [Q_W-1:0]     rpm;

  modport source (
    output valid, output delta_counts, output travel_counts, output travel_revolutions,
    output distance_delta, output velocity, output rpm, input ready
  );
  modport sink (
    input valid, input delta_counts, input travel_counts, input travel_revolutions,
    input distance_delta, input velocity, input rpm, output ready
  );
endinterface

@@ hdl/est_regs.sv @@
module est_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [est_pkg::ADDR_W-1:0] paddr,
  input  logic [est_pkg::DATA_W-1:0] pwdata,
  output logic [est_pkg::DATA_W-1:0] prdata,
  output est_pkg::cfg_t              cfg
);
  import est_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cpr <= CPR_RST;
      cfg.wc  <= WC_RST;
      cfg.per <= PER_RST;
      cfg.nlr <= NLR_RST;
    end else if (wr) begin
      case (idx)
        REG_CPR: cfg.cpr <= pwdata[CPR_W-1:0];
        REG_WC:  cfg.wc  <= pwdata[WC_W-1:0];
        REG_PER: cfg.per <= pwdata[PER_W-1:0];
        REG_NLR: cfg.nlr <= pwdata[NLR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CPR: prdata = DATA_W'(cfg.cpr);
      REG_WC:  prdata = DATA_W'(cfg.wc);
      REG_PER: prdata = DATA_W'(cfg.per);
      REG_NLR: prdata = DATA_W'(cfg.nlr);
      default: prdata = '0;
    endcase
  end

endmodule

@@ hdl/est_ctrl.sv @@
module est_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  est_pkg::status_t status,
  output est_pkg::cmd_t    cmd
);
  import est_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_INIT = 6'b000100,
    S_STEP = 6'b001000,
    S_FIN  = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  state_t state, state_next;
  op_t    op, op_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    op_next    = op;
    cmd        = '0;
    cmd.op     = op;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          op_next    = OP_DIST;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_INIT;
      end
      S_INIT: begin
        cmd.div_init = 1'b1;
        state_next   = S_STEP;
      end
      S_STEP: begin
        cmd.div_step = 1'b1;
        if (status.step_last) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        case (op)
          OP_DIST: begin
            op_next    = OP_VEL;
            state_next = S_MUL;
          end
          OP_VEL: begin
            op_next    = OP_RPM;
            state_next = S_MUL;
          end
          default: state_next = S_EMIT;
        endcase
      end
      S_EMIT: begin
        // wait for the output register to free up
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= OP_DIST;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      op    <= op_next;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

@@ hdl/est_datapath.sv @@
module est_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  est_pkg::cmd_t                     cmd,
  input  est_pkg::cfg_t                     cfg,
  input  logic [est_pkg::CNT_W-1:0]         counter_value,
  output est_pkg::status_t                  status,
  output logic signed [est_pkg::DELTA_W-1:0] delta_counts,
  output logic signed [est_pkg::TRV_W-1:0]   travel_counts,
  output logic signed [est_pkg::Q_W-1:0]     travel_revolutions,
  output logic signed [est_pkg::Q_W-1:0]     distance_delta,
  output logic signed [est_pkg::Q_W-1:0]     velocity,
  output logic signed [est_pkg::Q_W-1:0]     rpm
);
  import est_pkg::*;

  // tracking state
  logic        [CNT_W-1:0] prev_count;
  logic signed [ACC_W-1:0] acc;
  logic        [Q_W-1:0]   revs;

  // per-item working registers
  logic        [CNT_W-1:0] mag_r;
  logic                    neg_r;
  logic        [CNT_W-1:0] delta_r;
  logic        [DEN_W-1:0] den_rpm;
  logic        [Q_W-1:0]   dist_r;
  logic        [Q_W-1:0]   dist_mag;
  logic                    dist_neg;
  logic        [Q_W-1:0]   vel_r;
  logic        [Q_W-1:0]   rpm_r;

  // multiplier and divider
  logic [PROD_W-1:0] prod;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den_r;
  logic [Q_W-1:0]    qsh;
  logic              ovf_r;
  logic [STEP_W-1:0] cnt;

  // delta and travel
  logic        [CNT_W-1:0] raw;
  logic                    neg;
  logic        [CNT_W-1:0] mag;
  logic signed [SUM_W-1:0] t0, t1, cpr_s;
  logic        [Q_W-1:0]   revs_next;

  always_comb begin
    raw       = counter_value - prev_count;
    neg       = raw[CNT_W-1];
    mag       = neg ? (~raw + CNT_W'(1)) : raw;
    cpr_s     = SUM_W'(signed'({1'b0, cfg.cpr}));
    t0        = SUM_W'(acc) + SUM_W'(signed'(raw));
    t1        = t0;
    revs_next = revs;
    if (mag < cfg.cpr) begin
      if (t0 > cpr_s) begin
        t1        = t0 - cpr_s;
        revs_next = revs + Q_W'(1);
      end else if (t0 < -cpr_s) begin
        t1        = t0 + cpr_s;
        revs_next = revs - Q_W'(1);
      end
    end else begin
      t1 = SUM_W'(acc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_count <= '0;
      acc        <= '0;
      revs       <= '0;
    end else if (cmd.load) begin
      prev_count <= counter_value;
      acc        <= t1[ACC_W-1:0];
      revs       <= revs_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_r   <= mag;
      neg_r   <= neg;
      delta_r <= raw[DELTA_W-1:0];
      den_rpm <= cfg.cpr * cfg.per;
    end
  end

  // shared multiplier
  logic [Q_W-1:0] opa, opb;

  always_comb begin
    case (cmd.op)
      OP_DIST: begin
        opa = Q_W'(mag_r);
        opb = cfg.wc;
      end
      OP_VEL: begin
        opa = dist_mag;
        opb = VEL_K;
      end
      OP_RPM: begin
        opa = Q_W'(mag_r);
        opb = RPM_K;
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) prod <= opa * opb;
  end

  // divider set-up: a quotient of 2^Q_W or more is flagged in ovf_r
  logic [PROD_W-1:0] num;
  logic [DEN_W-1:0]  den;

  always_comb begin
    case (cmd.op)
      OP_DIST: begin
        num = prod;
        den = DEN_W'(cfg.cpr);
      end
      OP_VEL: begin
        num = prod;
        den = DEN_W'(cfg.per);
      end
      OP_RPM: begin
        num = {prod[PROD_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
        den = den_rpm;
      end
      default: begin
        num = '0;
        den = '0;
      end
    endcase
  end

  // two restoring steps per cycle
  logic [DEN_W:0] r1, r1s, r2, r2s;
  logic           b1, b2;

  always_comb begin
    r1  = {rem, qsh[Q_W-1]};
    b1  = (r1 >= {1'b0, den_r});
    r1s = b1 ? (r1 - {1'b0, den_r}) : r1;
    r2  = {r1s[DEN_W-1:0], qsh[Q_W-2]};
    b2  = (r2 >= {1'b0, den_r});
    r2s = b2 ? (r2 - {1'b0, den_r}) : r2;
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      ovf_r <= (DEN_W'(num[PROD_W-1:Q_W]) >= den);
      rem   <= DEN_W'(num[PROD_W-1:Q_W]);
      qsh   <= num[Q_W-1:0];
      den_r <= den;
    end else if (cmd.div_step) begin
      rem <= r2s[DEN_W-1:0];
      qsh <= {qsh[Q_W-3:0], b1, b2};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) cnt <= '0;
    else if (cmd.div_init) cnt <= '0;
    else if (cmd.div_step) cnt <= cnt + STEP_W'(1);
  end

  assign status.step_last = (cnt == STEP_W'(STEPS - 1));

  // rounding, saturation and clamping
  logic [DEN_W:0]       rnd_sum;
  logic                 round_up;
  logic [Q_W:0]         qr;
  logic                 big;
  logic                 sat_neg;
  logic [Q_W-1:0]       lim;
  logic [Q_W-1:0]       sat_mag;
  logic [Q_W-1:0]       sat_val;
  logic [FRAC_W-1:0]    ip;
  logic                 clamp;
  logic [Q_W-1:0]       rm;
  logic                 no_cpr, no_per;

  always_comb begin
    rnd_sum  = {1'b0, rem} + {1'b0, den_r >> 1};
    round_up = (rnd_sum >= {1'b0, den_r});
    qr       = {1'b0, qsh} + (Q_W+1)'(round_up);
    big      = ovf_r | qr[Q_W];
    sat_neg  = (cmd.op == OP_DIST) ? neg_r : dist_neg;
    lim      = sat_neg ? NEG_LIM : POS_LIM;
    sat_mag  = (big || (qr[Q_W-1:0] > lim)) ? lim : qr[Q_W-1:0];
    sat_val  = sat_neg ? (~sat_mag + Q_W'(1)) : sat_mag;
    ip       = qsh[Q_W-1:FRAC_W];
    clamp    = ovf_r || (ip > FRAC_W'(cfg.nlr)) ||
               ((ip == FRAC_W'(cfg.nlr)) && ((qsh[FRAC_W-1:0] != '0) || (rem != '0)));
    rm       = clamp ? {1'b0, cfg.nlr, {FRAC_W{1'b0}}} : qr[Q_W-1:0];
    no_cpr   = (cfg.cpr == '0);
    no_per   = (cfg.per == '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      case (cmd.op)
        OP_DIST: begin
          if (no_cpr) begin
            dist_r   <= '0;
            dist_mag <= '0;
            dist_neg <= 1'b0;
          end else begin
            dist_r   <= sat_val;
            dist_mag <= sat_mag;
            dist_neg <= neg_r & (sat_mag != '0);
          end
        end
        OP_VEL: vel_r <= (no_cpr || no_per) ? '0 : sat_val;
        OP_RPM: rpm_r <= (no_cpr || no_per) ? '0 : (neg_r ? (~rm + Q_W'(1)) : rm);
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      delta_counts       <= signed'(delta_r);
      travel_counts      <= acc[TRV_W-1:0];
      travel_revolutions <= signed'(revs);
      distance_delta     <= signed'(dist_r);
      velocity           <= signed'(vel_r);
      rpm                <= signed'(rpm_r);
    end
  end

endmodule

@@ hdl/encoder_speed_travel_tracker.sv @@
// A new sample is taken only after the previous one has been fully processed and its
// result has been loaded into the output register.
// The shared divider runs three divisions of 16 two-bit steps each per sample.
// A finished result waits in the output register while the next sample is taken.
// Reset (rst, synchronous) clears the count history, travel and revolution state,
// drops any pending result and returns the registers to their defaults.
module encoder_speed_travel_tracker (
  input  logic                       clk,
  input  logic                       rst,
  est_sample_if.sink                 sample,
  est_result_if.source               result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [est_pkg::ADDR_W-1:0] paddr,
  input  logic [est_pkg::DATA_W-1:0] pwdata,
  output logic [est_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import est_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  assign pready = 1'b1;

  est_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  est_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  est_datapath u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .cfg                (cfg),
    .counter_value      (sample.counter_value),
    .status             (status),
    .delta_counts       (result.delta_counts),
    .travel_counts      (result.travel_counts),
    .travel_revolutions (result.travel_revolutions),
    .distance_delta     (result.distance_delta),
    .velocity           (result.velocity),
    .rpm                (result.rpm)
  );

endmodule

@@ hdl/est_checker.sv @@
module est_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [est_pkg::DELTA_W-1:0] delta_counts,
  input logic signed [est_pkg::TRV_W-1:0]   travel_counts,
  input logic signed [est_pkg::Q_W-1:0]     travel_revolutions,
  input logic signed [est_pkg::Q_W-1:0]     distance_delta,
  input logic signed [est_pkg::Q_W-1:0]     velocity,
  input logic signed [est_pkg::Q_W-1:0]     rpm
);
  import est_pkg::*;

  logic in_xfer;

  assign in_xfer = in_valid & in_ready;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(delta_counts) &&
      $stable(travel_counts) && $stable(travel_revolutions) &&
      $stable(distance_delta) && $stable(velocity) && $stable(rpm))
    else $error("result changed while stalled");

  // reset drops any pending result
  a_rst_clear: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // one sample in flight: no second transfer straight after one
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> !in_ready)
    else $error("sample taken while previous one in work");

  // a result never appears in the cycle after a sample transfer
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> !$rose(out_valid))
    else $error("result appeared too early");

endmodule

bind encoder_speed_travel_tracker est_checker u_chk (
  .clk                (clk),
  .rst                (rst),
  .in_valid           (sample.valid),
  .in_ready           (sample.ready),
  .out_valid          (result.valid),
  .out_ready          (result.ready),
  .delta_counts       (result.delta_counts),
  .travel_counts      (result.travel_counts),
  .travel_revolutions (result.travel_revolutions),
  .distance_delta     (result.distance_delta),
  .velocity           (result.velocity),
  .rpm                (result.rpm)
);
